[design/fttb_pkg.sv]
`default_nettype none

package fttb_pkg;

  // Input item commands
  localparam logic CMD_FACE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Result kinds
  localparam logic KIND_TRI   = 1'b0;
  localparam logic KIND_BATCH = 1'b1;

  // Register map: index = paddr[3:2]
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_LIGHTMAP_ONLY = 2'd0;
  localparam logic [1:0] REG_COPY_MODE     = 2'd1;
  localparam logic [1:0] REG_WHITE_TEXTURE = 2'd2;
  localparam logic [15:0] WHITE_TEXTURE_RST = 16'd1;

  typedef struct packed {
    logic        command;
    logic [19:0] first_vertex;
    logic [5:0]  edge_count;
    logic [15:0] base_texture;
    logic [15:0] glow_texture;
    logic [15:0] lightmap_texture;
    logic [31:0] state_bits;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [19:0] index_a;
    logic [19:0] index_b;
    logic [19:0] index_c;
    logic [14:0] batch_indices;
    logic [12:0] batch_vertices;
    logic [15:0] batch_base_texture;
    logic [15:0] batch_lightmap_texture;
    logic [15:0] batch_glow_texture;
    logic [31:0] batch_state;
    logic        last;
  } result_t;

  typedef struct packed {
    logic        lightmap_only;
    logic        copy_mode;
    logic [15:0] white_texture;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic load_close;
    logic start_face;
    logic load_tri;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic slot_free;
    logic close_req;
    logic is_face;
    logic tri_last;
  } sts_t;

endpackage

`default_nettype wire

[design/fttb_regs.sv]
`default_nettype none

module fttb_regs
  import fttb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lightmap_only <= 1'b0;
      cfg.copy_mode     <= 1'b0;
      cfg.white_texture <= WHITE_TEXTURE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LIGHTMAP_ONLY: cfg.lightmap_only <= pwdata[0];
        REG_COPY_MODE:     cfg.copy_mode     <= pwdata[0];
        REG_WHITE_TEXTURE: cfg.white_texture <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_LIGHTMAP_ONLY: prdata = {31'd0, cfg.lightmap_only};
      REG_COPY_MODE:     prdata = {31'd0, cfg.copy_mode};
      REG_WHITE_TEXTURE: prdata = {16'd0, cfg.white_texture};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/fttb_ctrl.sv]
`default_nettype none

module fttb_ctrl
  import fttb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic      item_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_CLOSE    = 5'b00100,
    S_FACE     = 5'b01000,
    S_TRI      = 5'b10000
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.close_req) begin
          state_next = S_CLOSE;
        end else if (sts.is_face) begin
          state_next = S_FACE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (sts.slot_free) begin
          cmd.load_close = 1'b1;
          state_next     = sts.is_face ? S_FACE : S_IDLE;
        end
      end
      S_FACE: begin
        cmd.start_face = 1'b1;
        state_next     = S_TRI;
      end
      S_TRI: begin
        if (sts.slot_free) begin
          cmd.load_tri = 1'b1;
          if (sts.tri_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[design/fttb_dp.sv]
`default_nettype none

module fttb_dp
  import fttb_pkg::*;
#(
  parameter int MAX_VERTS   = 4096,
  parameter int MAX_INDICES = 16384,
  parameter int MAX_EDGES   = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire cmd_t  cmd,
  output sts_t       sts,
  output logic       result_valid,
  input  wire logic  result_ready,
  output result_t    result
);

  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int TW = $clog2(MAX_EDGES - 1);
  localparam int IW = $clog2(MAX_INDICES + 1);
  localparam int VW = $clog2(MAX_VERTS + 1);

  // Open batch state
  logic [15:0]   cur_base, cur_lmap, cur_glow;
  logic [31:0]   cur_flags;
  logic [IW-1:0] index_total;
  logic [VW-1:0] vertex_total;

  // Captured item
  logic          cap_end, cap_close, cap_face;
  logic [15:0]   cap_base, cap_lmap, cap_glow;
  logic [31:0]   cap_flags;
  logic [19:0]   cap_first;
  logic [EW-1:0] cap_edges;
  logic [TW-1:0] cap_ntris;
  logic [IW-1:0] cap_nidx;

  // Fan walk
  logic [19:0]   jv;
  logic [TW-1:0] tri_i;

  // Next output beat
  result_t       result_next;

  // Resolve textures and edge count of the incoming item
  logic          in_end, in_ignore, nonempty, key_diff, idx_ovf, vtx_ovf;
  logic [15:0]   r_base, r_glow;
  logic [EW-1:0] r_edges;
  logic [TW-1:0] r_ntris;
  logic [IW-1:0] r_nidx;
  logic [IW:0]   idx_sum;
  logic [VW:0]   vtx_sum;

  always_comb begin
    in_end    = (item.command == CMD_END);
    in_ignore = (item.edge_count < 6'd3);
    if (32'(item.edge_count) > 32'(MAX_EDGES)) begin
      r_edges = EW'(MAX_EDGES);
    end else begin
      r_edges = EW'(item.edge_count);
    end
    r_ntris = TW'(r_edges - EW'(2));
    r_nidx  = IW'({r_ntris, 1'b0}) + IW'(r_ntris);
    if (cfg.lightmap_only && item.lightmap_texture != 16'd0) begin
      r_base = cfg.white_texture;
      r_glow = 16'd0;
    end else begin
      r_base = item.base_texture;
      r_glow = (item.lightmap_texture != 16'd0) ? item.glow_texture : 16'd0;
    end
    key_diff = (cur_base != r_base) || (cur_lmap != item.lightmap_texture) ||
               (cur_glow != r_glow) || (cur_flags != item.state_bits);
    idx_sum  = (IW+1)'(index_total) + (IW+1)'(r_nidx);
    vtx_sum  = (VW+1)'(vertex_total) + (VW+1)'(r_edges);
    idx_ovf  = idx_sum > (IW+1)'(MAX_INDICES);
    vtx_ovf  = cfg.copy_mode && (vtx_sum > (VW+1)'(MAX_VERTS));
    nonempty = (index_total != '0);
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_end   <= in_end;
      cap_face  <= !in_end && !in_ignore;
      cap_close <= nonempty &&
                   (in_end || (!in_ignore && (key_diff || idx_ovf || vtx_ovf)));
      cap_base  <= r_base;
      cap_lmap  <= item.lightmap_texture;
      cap_glow  <= r_glow;
      cap_flags <= item.state_bits;
      cap_first <= item.first_vertex;
      cap_edges <= r_edges;
      cap_ntris <= r_ntris;
      cap_nidx  <= r_nidx;
    end
  end

  // Batch keys and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_base     <= '0;
      cur_lmap     <= '0;
      cur_glow     <= '0;
      cur_flags    <= '0;
      index_total  <= '0;
      vertex_total <= '0;
    end else if (cmd.load_close) begin
      index_total  <= '0;
      vertex_total <= '0;
      if (cap_end) begin
        cur_base  <= '0;
        cur_lmap  <= '0;
        cur_glow  <= '0;
        cur_flags <= '0;
      end
    end else if (cmd.start_face) begin
      cur_base    <= cap_base;
      cur_lmap    <= cap_lmap;
      cur_glow    <= cap_glow;
      cur_flags   <= cap_flags;
      index_total <= index_total + cap_nidx;
      if (cfg.copy_mode) begin
        vertex_total <= vertex_total + VW'(cap_edges);
      end
    end
  end

  // Fan pivot and triangle counter
  always_ff @(posedge clk) begin
    if (cmd.start_face) begin
      jv    <= cfg.copy_mode ? 20'(vertex_total) : cap_first;
      tri_i <= '0;
    end else if (cmd.load_tri) begin
      tri_i <= tri_i + TW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_close || cmd.load_tri) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Batch-closed or triangle beat
  always_comb begin
    result_next = '0;
    if (cmd.load_close) begin
      result_next.kind                   = KIND_BATCH;
      result_next.batch_indices          = 15'(index_total);
      result_next.batch_vertices         = 13'(vertex_total);
      result_next.batch_base_texture     = cur_base;
      result_next.batch_lightmap_texture = cur_lmap;
      result_next.batch_glow_texture     = cur_glow;
      result_next.batch_state            = cur_flags;
      result_next.last                   = cap_end;
    end else begin
      result_next.kind    = KIND_TRI;
      result_next.index_a = jv;
      result_next.index_b = jv + 20'(tri_i) + 20'd1;
      result_next.index_c = jv + 20'(tri_i) + 20'd2;
      result_next.last    = sts.tri_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_close || cmd.load_tri) begin
      result <= result_next;
    end
  end

  // Status back to the controller
  assign sts.slot_free = !result_valid || result_ready;
  assign sts.close_req = cap_close;
  assign sts.is_face   = cap_face;
  assign sts.tri_last  = (tri_i == cap_ntris - TW'(1));

endmodule

`default_nettype wire

[design/fan_to_triangle_batcher.sv]
// Triangle fan to indexed triangle list batcher.
// Input channel (item_valid/item_ready/item): one beat per polygon face or
// end-of-batch command. Output channel (result_valid/result_ready/result):
// triangle beats and batch-closed beats; result.last marks the final beat
// caused by an item. An item that causes nothing yields no beat.
// Config: APB port, lightmap_only at 0x0, copy_mode at 0x4, white_texture at
// 0x8; write only while the block is idle.
// Timing: one item is in flight at a time. After acceptance a decode state
// follows, then an optional batch-closed beat, a face setup state, and one
// triangle beat per cycle while the output is not stalled (edge count,
// clamped to MAX_EDGES, minus two). The next item is accepted once the last
// beat has been loaded into the output register, even if that beat is
// still waiting.
// Stall: while result_ready is low, the output register holds its beat and
// the sequencer waits before loading the next one.
// Reset (rst, synchronous): empty batch with zero keys, no pending beat,
// registers at their reset values.
`default_nettype none

module fan_to_triangle_batcher
  import fttb_pkg::*;
#(
  parameter int MAX_VERTS   = 4096,
  parameter int MAX_INDICES = 16384,
  parameter int MAX_EDGES   = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  fttb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fttb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  fttb_dp #(
    .MAX_VERTS   (MAX_VERTS),
    .MAX_INDICES (MAX_INDICES),
    .MAX_EDGES   (MAX_EDGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import fttb_pkg::*;

  localparam int FAN_MAX_EDGES   = 32;
  localparam int BATCH_MAX_VERTS = 4096;
  localparam int BATCH_MAX_IDX   = 16384;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_CYCLES     = 400;

  // Texture and state keys shared by a run of faces
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] glow;
    logic [15:0] lmap;
    logic [31:0] flags;
  } material_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_t             item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Stimulus and expectation stores
  item_t     pending_items[$];
  result_t   expected_beats[$];
  material_t palette[4];

  // Idle control, written by the sequence at the falling edge
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_sender = 1'b0;
  bit          hold_receiver = 1'b0;

  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // Shadow of the register file
  logic        cfg_lmap_only = 1'b0;
  logic        cfg_copy = 1'b0;
  logic [15:0] cfg_white = WHITE_TEXTURE_RST;

  // Shadow of the open batch
  logic [15:0] cur_base = '0;
  logic [15:0] cur_lmap = '0;
  logic [15:0] cur_glow = '0;
  logic [31:0] cur_flags = '0;
  int unsigned idx_total = 0;
  int unsigned vtx_total = 0;

  fan_to_triangle_batcher dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Closes the open batch if it holds any index
  task automatic emit_batch_close(input bit clear_keys, input bit is_last);
    result_t r;
    if (idx_total == 0) return;
    r = '0;
    r.kind = KIND_BATCH;
    r.batch_indices = 15'(idx_total);
    r.batch_vertices = 13'(vtx_total);
    r.batch_base_texture = cur_base;
    r.batch_lightmap_texture = cur_lmap;
    r.batch_glow_texture = cur_glow;
    r.batch_state = cur_flags;
    r.last = is_last;
    expected_beats.push_back(r);
    idx_total = 0;
    vtx_total = 0;
    if (clear_keys) begin
      cur_base = '0;
      cur_lmap = '0;
      cur_glow = '0;
      cur_flags = '0;
    end
  endtask

  // Expected beats for one accepted item
  task automatic compute_fan_beats(input item_t it);
    int unsigned edges;
    int unsigned ntris;
    int unsigned k;
    logic [15:0] base;
    logic [15:0] lmap;
    logic [15:0] glow;
    logic [31:0] flags;
    logic [19:0] pivot;
    result_t     r;
    if (it.command == CMD_END) begin
      emit_batch_close(1'b1, 1'b1);
      return;
    end
    edges = 32'(it.edge_count);
    if (edges < 3) return;
    if (edges > FAN_MAX_EDGES) edges = FAN_MAX_EDGES;
    ntris = edges - 2;

    // texture resolution, lightmap-only override
    lmap = it.lightmap_texture;
    flags = it.state_bits;
    if (cfg_lmap_only && lmap != 0) begin
      base = cfg_white;
      glow = '0;
    end else begin
      base = it.base_texture;
      glow = (lmap != 0) ? it.glow_texture : 16'h0000;
    end

    if (cur_base != base || cur_lmap != lmap || cur_glow != glow ||
        cur_flags != flags || idx_total + 3 * ntris > BATCH_MAX_IDX)
      emit_batch_close(1'b1, 1'b0);
    cur_base = base;
    cur_lmap = lmap;
    cur_glow = glow;
    cur_flags = flags;

    // vertex overflow close keeps the new keys
    if (cfg_copy) begin
      if (vtx_total + edges > BATCH_MAX_VERTS) emit_batch_close(1'b0, 1'b0);
      pivot = 20'(vtx_total);
      vtx_total += edges;
    end else begin
      pivot = it.first_vertex;
    end

    for (k = 0; k < ntris; k++) begin
      r = '0;
      r.kind = KIND_TRI;
      r.index_a = pivot;
      r.index_b = pivot + 20'(k + 1);
      r.index_c = pivot + 20'(k + 2);
      r.last = (k == ntris - 1);
      expected_beats.push_back(r);
    end
    idx_total += 3 * ntris;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic check_beat(input result_t got);
    result_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing pending, kind", '0, 32'(got.kind));
      return;
    end
    want = expected_beats.pop_front();
    if (got.kind !== want.kind)
      report_mismatch("kind", 32'(want.kind), 32'(got.kind));
    if (got.index_a !== want.index_a)
      report_mismatch("index_a", 32'(want.index_a), 32'(got.index_a));
    if (got.index_b !== want.index_b)
      report_mismatch("index_b", 32'(want.index_b), 32'(got.index_b));
    if (got.index_c !== want.index_c)
      report_mismatch("index_c", 32'(want.index_c), 32'(got.index_c));
    if (got.batch_indices !== want.batch_indices)
      report_mismatch("batch_indices", 32'(want.batch_indices), 32'(got.batch_indices));
    if (got.batch_vertices !== want.batch_vertices)
      report_mismatch("batch_vertices", 32'(want.batch_vertices),
                      32'(got.batch_vertices));
    if (got.batch_base_texture !== want.batch_base_texture)
      report_mismatch("batch_base_texture", 32'(want.batch_base_texture),
                      32'(got.batch_base_texture));
    if (got.batch_lightmap_texture !== want.batch_lightmap_texture)
      report_mismatch("batch_lightmap_texture", 32'(want.batch_lightmap_texture),
                      32'(got.batch_lightmap_texture));
    if (got.batch_glow_texture !== want.batch_glow_texture)
      report_mismatch("batch_glow_texture", 32'(want.batch_glow_texture),
                      32'(got.batch_glow_texture));
    if (got.batch_state !== want.batch_state)
      report_mismatch("batch_state", want.batch_state, got.batch_state);
    if (got.last !== want.last)
      report_mismatch("last", 32'(want.last), 32'(got.last));
  endtask

  // Input driver: predicts on each accepted beat, then offers the next item
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) compute_fan_beats(item);
      if (!item_valid || item_ready) begin
        if (pending_items.size() != 0 && !hold_sender &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) check_beat(result);
      result_ready <= !hold_receiver && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LIGHTMAP_ONLY: cfg_lmap_only = value[0];
      REG_COPY_MODE:     cfg_copy = value[0];
      REG_WHITE_TEXTURE: cfg_white = value[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Waits until the block has nothing left in flight
  task automatic drain_block();
    while (pending_items.size() != 0 || item_valid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic item_t face_item(input logic [19:0] fv, input logic [5:0] edges,
                                      input logic [15:0] base, input logic [15:0] glow,
                                      input logic [15:0] lmap, input logic [31:0] flags);
    item_t it;
    it.command = CMD_FACE;
    it.first_vertex = fv;
    it.edge_count = edges;
    it.base_texture = base;
    it.glow_texture = glow;
    it.lightmap_texture = lmap;
    it.state_bits = flags;
    return it;
  endfunction

  // Face with every field but the command random
  function automatic item_t rand_face_item();
    return face_item(20'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), $urandom);
  endfunction

  // End command with junk in the unused fields
  function automatic item_t end_item();
    item_t it;
    it = rand_face_item();
    it.command = CMD_END;
    return it;
  endfunction

  function automatic material_t rand_material();
    material_t m;
    m.base = 16'($urandom);
    m.glow = 16'($urandom);
    m.lmap = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
    m.flags = $urandom;
    return m;
  endfunction

  // Mostly ordinary fans, some degenerate and some oversized
  function automatic logic [5:0] pick_edge_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 6'($urandom_range(0, 2));
    if (roll < 12) return 6'($urandom_range(33, 63));
    if (roll < 20) return 6'd32;
    return 6'($urandom_range(3, 12));
  endfunction

  // Runs of faces on a few materials, with end commands and noise
  task automatic push_mixed(input int unsigned count);
    int unsigned n;
    int unsigned roll;
    int unsigned cur;
    material_t   m;
    for (n = 0; n < 4; n++) palette[n] = rand_material();
    cur = 0;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        pending_items.push_back(end_item());
      end else if (roll < 13) begin
        pending_items.push_back(rand_face_item());
      end else begin
        if (roll < 25) cur = $urandom_range(0, 3);
        m = palette[cur];
        // differing base still merges when the lightmap override applies
        if (roll >= 90) m.base = 16'($urandom);
        pending_items.push_back(face_item(20'($urandom), pick_edge_count(), m.base,
                                          m.glow, m.lmap, m.flags));
      end
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned k;
    logic        lo;
    logic        cm;
    logic [15:0] wt;
    material_t   mat;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty batch, degenerate fans, wrap, saturation, key changes
    pending_items.push_back(end_item());
    for (k = 0; k < 3; k++)
      pending_items.push_back(face_item(20'($urandom), 6'(k), 16'($urandom),
                                        16'($urandom), 16'($urandom), $urandom));
    pending_items.push_back(face_item(20'h00000, 6'd3, 16'h0, 16'h0, 16'h0, 32'h0));
    pending_items.push_back(face_item(20'hFFFFF, 6'd32, 16'h0, 16'h0, 16'h0, 32'h0));
    pending_items.push_back(face_item(20'hFFFF0, 6'd63, 16'h0001, 16'h0, 16'h0, 32'h0));
    pending_items.push_back(face_item(20'h00000, 6'd33, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      32'hFFFF_FFFF));
    pending_items.push_back(face_item(20'hABCDE, 6'd4, 16'hFFFF, 16'hFFFF, 16'h0,
                                      32'hFFFF_FFFF));
    pending_items.push_back(end_item());
    pending_items.push_back(end_item());
    pending_items.push_back(face_item(20'($urandom), 6'd32, 16'($urandom),
                                      16'($urandom), 16'($urandom), $urandom));
    drain_block();

    // Directed: lightmap override and copied vertices
    cfg_write(REG_LIGHTMAP_ONLY, 32'd1);
    cfg_write(REG_COPY_MODE, 32'd1);
    cfg_write(REG_WHITE_TEXTURE, 32'h0000_FFFF);
    pending_items.push_back(face_item(20'($urandom), 6'd5, 16'h1234, 16'h5678, 16'h9ABC,
                                      32'h0));
    pending_items.push_back(face_item(20'($urandom), 6'd6, 16'h4321, 16'h1111, 16'h9ABC,
                                      32'h0));
    pending_items.push_back(face_item(20'($urandom), 6'd3, 16'h4321, 16'h1111, 16'h0,
                                      32'h0));
    pending_items.push_back(end_item());
    drain_block();

    // Random phases, each with its own settings and idle pattern
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin lo = 1'b0; cm = 1'b0; wt = 16'h1234; end
        1: begin lo = 1'b1; cm = 1'b1; wt = 16'hFFFF; end
        2: begin lo = 1'b1; cm = 1'b0; wt = 16'h0000; end
        3: begin lo = 1'b0; cm = 1'b1; wt = 16'($urandom); end
        default: begin
          lo = 1'($urandom_range(0, 1));
          cm = 1'($urandom_range(0, 1));
          wt = 16'($urandom);
        end
      endcase
      cfg_write(REG_LIGHTMAP_ONLY, {31'b0, lo});
      cfg_write(REG_COPY_MODE, {31'b0, cm});
      cfg_write(REG_WHITE_TEXTURE, {16'b0, wt});

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase

      case (p)
        0: begin
          // one material of large fans until the index store overflows
          mat = rand_material();
          for (k = 0; k < 185; k++)
            pending_items.push_back(face_item(20'($urandom), 6'd32, mat.base, mat.glow,
                                              mat.lmap, mat.flags));
        end
        1: begin
          // copied fans until the vertex store overflows
          mat = rand_material();
          if (mat.lmap == 0) mat.lmap = 16'h0001;
          for (k = 0; k < 150; k++)
            pending_items.push_back(face_item(20'($urandom), 6'($urandom_range(30, 32)),
                                              16'($urandom), mat.glow, mat.lmap,
                                              mat.flags));
        end
        2: begin
          // receiver holds off so the block backs up into the input
          hold_receiver = 1'b1;
          push_mixed(25);
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_receiver = 1'b0;
        end
        3: begin
          // sender pauses until the output side has caught up
          push_mixed(12);
          while (pending_items.size() != 0) @(negedge clk);
          hold_sender = 1'b1;
          push_mixed(13);
          while (item_valid || expected_beats.size() != 0) @(negedge clk);
          hold_sender = 1'b0;
        end
        default: push_mixed(25);
      endcase
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
